@@ rtl/camera_reprojection_error_top_assert.svh @@
// Assertion macros used by the checker of this block.
`ifndef CAMERA_REPROJECTION_ERROR_TOP_ASSERT_SVH
`define CAMERA_REPROJECTION_ERROR_TOP_ASSERT_SVH

// Overlapping implication, checked while out of reset.
`define CRE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Non-overlapping implication, consequent checked in the next cycle, while out of reset.
`define CRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Non-overlapping implication, consequent checked in the next cycle, including during reset.
`define CRE_ASSERT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/cre_pkg.sv @@
`timescale 1ns / 1ps
package cre_pkg;

    localparam int DIV_BITS  = 34;
    localparam int SQRT_BITS = 32;
    localparam int IDX_W     = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_ROW0_FIRST  = 3'd0,
        REG_ROW0_SECOND = 3'd1,
        REG_ROW1_FIRST  = 3'd2,
        REG_ROW1_SECOND = 3'd3,
        REG_ROW2_FIRST  = 3'd4,
        REG_ROW2_SECOND = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic               degen;
        logic               neg_u;
        logic               neg_v;
        logic               clamp_u;
        logic               clamp_v;
        logic signed [31:0] meas_u;
        logic signed [31:0] meas_v;
    } t_dside;

    typedef struct packed {
        logic degen;
        logic sat;
    } t_qside;

endpackage

@@ rtl/cre_if.sv @@
`timescale 1ns / 1ps
interface cre_pt_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic signed [31:0] world_w;
    logic signed [31:0] image_u;
    logic signed [31:0] image_v;
    modport source(output valid, world_x, world_y, world_z, world_w, image_u, image_v,
                   input ready);
    modport sink(input valid, world_x, world_y, world_z, world_w, image_u, image_v,
                 output ready);
endinterface

interface cre_err_if;
    logic        valid;
    logic        ready;
    logic [31:0] error_distance;
    logic        degenerate;
    modport source(output valid, error_distance, degenerate, input ready);
    modport sink(input valid, error_distance, degenerate, output ready);
endinterface

interface cre_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/camera_reprojection_error_top.sv @@
`timescale 1ns / 1ps
// Path of a point: r1-r3, the divider, r4-r6, the square root, the output register.
// Throughput: one point per cycle; the 34-stage divider and the 32-stage square root
// each resolve one bit per stage, and the whole pipeline holds when the output stalls.
// Reset clears all valid bits and the six camera matrix registers to zero.
module camera_reprojection_error_top
    import cre_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    cre_pt_if.sink    i_pt,
    cre_cfg_if.sink   i_cfg,
    cre_err_if.source o_err
);

    logic signed [31:0] r_mat [3][4];
    logic signed [31:0] w [4];
    logic               en;

    logic               r1_vld;
    logic signed [63:0] r1_prod [3][4];
    logic signed [31:0] r1_mu, r1_mv;

    logic               r2_vld;
    logic signed [63:0] r2_p [3];
    logic signed [31:0] r2_mu, r2_mv;

    logic               r3_vld;
    logic [63:0]        r3_au, r3_av, r3_b;
    t_dside             r3_side;
    logic [63:0]        a_u, a_v, b;

    t_dside              r_dside [DIV_BITS];
    logic                div_vld;
    logic [DIV_BITS-1:0] quo_u, quo_v;

    logic               r4_vld;
    logic [31:0]        r4_du, r4_dv;
    t_qside             r4_side;
    logic signed [35:0] q_u, q_v, d_u, d_v;
    logic [35:0]        m_u, m_v;

    logic               r5_vld;
    logic [63:0]        r5_su, r5_sv;
    t_qside             r5_side;

    logic               r6_vld;
    logic [63:0]        r6_sum;
    t_qside             r6_side;
    logic [64:0]        sum;

    t_qside               r_qside [SQRT_BITS];
    logic                 sq_vld;
    logic [SQRT_BITS-1:0] root;

    logic        r_out_vld;
    logic [31:0] r_out_err;
    logic        r_out_degen;

    assign en           = !r_out_vld || o_err.ready;
    assign i_pt.ready   = en;
    assign i_cfg.ready  = 1'b1;
    assign w[0] = i_pt.world_x;
    assign w[1] = i_pt.world_y;
    assign w[2] = i_pt.world_z;
    assign w[3] = i_pt.world_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_mat[r][c] <= '0;
                end
            end
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_ROW0_FIRST: begin
                    r_mat[0][0] <= i_cfg.data[31:0];
                    r_mat[0][1] <= i_cfg.data[63:32];
                end
                REG_ROW0_SECOND: begin
                    r_mat[0][2] <= i_cfg.data[31:0];
                    r_mat[0][3] <= i_cfg.data[63:32];
                end
                REG_ROW1_FIRST: begin
                    r_mat[1][0] <= i_cfg.data[31:0];
                    r_mat[1][1] <= i_cfg.data[63:32];
                end
                REG_ROW1_SECOND: begin
                    r_mat[1][2] <= i_cfg.data[31:0];
                    r_mat[1][3] <= i_cfg.data[63:32];
                end
                REG_ROW2_FIRST: begin
                    r_mat[2][0] <= i_cfg.data[31:0];
                    r_mat[2][1] <= i_cfg.data[63:32];
                end
                REG_ROW2_SECOND: begin
                    r_mat[2][2] <= i_cfg.data[31:0];
                    r_mat[2][3] <= i_cfg.data[63:32];
                end
                default: begin
                end
            endcase
        end
    end

    // Valid bits of the front and back stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r1_vld    <= i_pt.valid;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= div_vld;
            r5_vld    <= r4_vld;
            r6_vld    <= r5_vld;
            r_out_vld <= sq_vld;
        end
    end

    function automatic logic [63:0] f_abs(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    assign a_u = f_abs(r2_p[0]);
    assign a_v = f_abs(r2_p[1]);
    assign b   = f_abs(r2_p[2]);

    assign q_u = r_dside[DIV_BITS-1].clamp_u ? 36'sh4_0000_0000 : $signed({2'b00, quo_u});
    assign q_v = r_dside[DIV_BITS-1].clamp_v ? 36'sh4_0000_0000 : $signed({2'b00, quo_v});
    assign d_u = 36'(r_dside[DIV_BITS-1].meas_u)
               - (r_dside[DIV_BITS-1].neg_u ? -q_u : q_u);
    assign d_v = 36'(r_dside[DIV_BITS-1].meas_v)
               - (r_dside[DIV_BITS-1].neg_v ? -q_v : q_v);
    assign m_u = d_u[35] ? 36'(-d_u) : 36'(d_u);
    assign m_v = d_v[35] ? 36'(-d_v) : 36'(d_v);
    assign sum = {1'b0, r5_su} + {1'b0, r5_sv};

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r1_prod[r][c] <= 64'(r_mat[r][c]) * 64'(w[c]);
                end
                r2_p[r] <= (r1_prod[r][0] >>> 2) + (r1_prod[r][1] >>> 2)
                         + (r1_prod[r][2] >>> 2) + (r1_prod[r][3] >>> 2);
            end
            r1_mu <= i_pt.image_u;
            r1_mv <= i_pt.image_v;
            r2_mu <= r1_mu;
            r2_mv <= r1_mv;

            r3_au           <= a_u;
            r3_av           <= a_v;
            r3_b            <= b;
            r3_side.degen   <= r2_p[2] == '0;
            r3_side.neg_u   <= r2_p[0][63] ^ r2_p[2][63];
            r3_side.neg_v   <= r2_p[1][63] ^ r2_p[2][63];
            r3_side.clamp_u <= {18'b0, a_u} >= {b, 18'b0};
            r3_side.clamp_v <= {18'b0, a_v} >= {b, 18'b0};
            r3_side.meas_u  <= r2_mu;
            r3_side.meas_v  <= r2_mv;

            r_dside[0] <= r3_side;
            for (int k = 1; k < DIV_BITS; k++) begin
                r_dside[k] <= r_dside[k-1];
            end

            r4_du         <= m_u[31:0];
            r4_dv         <= m_v[31:0];
            r4_side.degen <= r_dside[DIV_BITS-1].degen;
            r4_side.sat   <= (m_u[35:32] != '0) || (m_v[35:32] != '0);

            r5_su   <= 64'(r4_du) * 64'(r4_du);
            r5_sv   <= 64'(r4_dv) * 64'(r4_dv);
            r5_side <= r4_side;

            r6_sum        <= sum[63:0];
            r6_side.degen <= r5_side.degen;
            r6_side.sat   <= r5_side.sat || sum[64];

            r_qside[0] <= r6_side;
            for (int k = 1; k < SQRT_BITS; k++) begin
                r_qside[k] <= r_qside[k-1];
            end

            r_out_degen <= r_qside[SQRT_BITS-1].degen;
            r_out_err   <= (r_qside[SQRT_BITS-1].degen || r_qside[SQRT_BITS-1].sat)
                         ? '1 : root;
        end
    end

    cre_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r3_vld),
        .i_num_u (r3_au),
        .i_num_v (r3_av),
        .i_den   (r3_b),
        .o_vld   (div_vld),
        .o_quo_u (quo_u),
        .o_quo_v (quo_v)
    );

    cre_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r6_vld),
        .i_sq    (r6_sum),
        .o_vld   (sq_vld),
        .o_root  (root)
    );

    assign o_err.valid          = r_out_vld;
    assign o_err.error_distance = r_out_err;
    assign o_err.degenerate     = r_out_degen;

endmodule

@@ rtl/cre_div.sv @@
`timescale 1ns / 1ps
module cre_div
    import cre_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [63:0]         i_num_u,
    input  logic [63:0]         i_num_v,
    input  logic [63:0]         i_den,
    output logic                o_vld,
    output logic [DIV_BITS-1:0] o_quo_u,
    output logic [DIV_BITS-1:0] o_quo_v
);

    logic                r_vld   [DIV_BITS+1];
    logic [63:0]         r_rem_u [DIV_BITS+1];
    logic [63:0]         r_rem_v [DIV_BITS+1];
    logic [63:0]         r_num_u [DIV_BITS+1];
    logic [63:0]         r_num_v [DIV_BITS+1];
    logic [63:0]         r_den   [DIV_BITS+1];
    logic [DIV_BITS-1:0] r_quo_u [DIV_BITS+1];
    logic [DIV_BITS-1:0] r_quo_v [DIV_BITS+1];

    assign r_vld[0]   = i_vld;
    assign r_rem_u[0] = i_num_u >> 18;
    assign r_rem_v[0] = i_num_v >> 18;
    assign r_num_u[0] = i_num_u;
    assign r_num_v[0] = i_num_v;
    assign r_den[0]   = i_den;
    assign r_quo_u[0] = '0;
    assign r_quo_v[0] = '0;

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
        localparam int QB = DIV_BITS - 1 - k;
        logic        nb_u, nb_v, ge_u, ge_v;
        logic [63:0] t_u, t_v;
        if (QB >= 16) begin : g_bit
            assign nb_u = r_num_u[k][QB-16];
            assign nb_v = r_num_v[k][QB-16];
        end else begin : g_zero
            assign nb_u = 1'b0;
            assign nb_v = 1'b0;
        end
        assign t_u  = {r_rem_u[k][62:0], nb_u};
        assign t_v  = {r_rem_v[k][62:0], nb_v};
        assign ge_u = t_u >= r_den[k];
        assign ge_v = t_v >= r_den[k];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_u[k+1] <= ge_u ? t_u - r_den[k] : t_u;
                r_rem_v[k+1] <= ge_v ? t_v - r_den[k] : t_v;
                r_quo_u[k+1] <= {r_quo_u[k][DIV_BITS-2:0], ge_u};
                r_quo_v[k+1] <= {r_quo_v[k][DIV_BITS-2:0], ge_v};
                r_num_u[k+1] <= r_num_u[k];
                r_num_v[k+1] <= r_num_v[k];
                r_den[k+1]   <= r_den[k];
            end
        end
    end

    assign o_vld   = r_vld[DIV_BITS];
    assign o_quo_u = r_quo_u[DIV_BITS];
    assign o_quo_v = r_quo_v[DIV_BITS];

endmodule

@@ rtl/cre_sqrt.sv @@
`timescale 1ns / 1ps
module cre_sqrt
    import cre_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [63:0]          i_sq,
    output logic                 o_vld,
    output logic [SQRT_BITS-1:0] o_root
);

    logic                 r_vld  [SQRT_BITS+1];
    logic [63:0]          r_sq   [SQRT_BITS+1];
    logic [35:0]          r_rem  [SQRT_BITS+1];
    logic [SQRT_BITS-1:0] r_root [SQRT_BITS+1];

    assign r_vld[0]  = i_vld;
    assign r_sq[0]   = i_sq;
    assign r_rem[0]  = '0;
    assign r_root[0] = '0;

    for (genvar k = 0; k < SQRT_BITS; k++) begin : g_stage
        localparam int J = SQRT_BITS - 1 - k;
        logic [35:0] t_rem, t_try;
        logic        ge;
        assign t_rem = {r_rem[k][33:0], r_sq[k][2*J+1 -: 2]};
        assign t_try = {2'b00, r_root[k], 2'b01};
        assign ge    = t_rem >= t_try;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[k+1]   <= r_sq[k];
                r_rem[k+1]  <= ge ? t_rem - t_try : t_rem;
                r_root[k+1] <= {r_root[k][SQRT_BITS-2:0], ge};
            end
        end
    end

    assign o_vld  = r_vld[SQRT_BITS];
    assign o_root = r_root[SQRT_BITS];

endmodule

@@ rtl/cre_checker.sv @@
`timescale 1ns / 1ps
`include "camera_reprojection_error_top_assert.svh"
module cre_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_pt_ready,
    input logic        i_cfg_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_error_distance,
    input logic        i_out_degenerate
);

    `CRE_ASSERT_RST(a_reset_clears, i_clk, !i_rst_n, !i_out_valid)
    `CRE_ASSERT_NOW(a_degen_sat, i_clk, i_rst_n, i_out_valid && i_out_degenerate, i_out_error_distance == 32'hFFFF_FFFF)
    `CRE_ASSERT_NOW(a_flow, i_clk, i_rst_n, i_out_ready, i_pt_ready && i_cfg_ready)
    `CRE_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_error_distance) && $stable(i_out_degenerate))

endmodule

bind camera_reprojection_error_top cre_checker u_cre_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_pt_ready           (i_pt.ready),
    .i_cfg_ready          (i_cfg.ready),
    .i_out_valid          (o_err.valid),
    .i_out_ready          (o_err.ready),
    .i_out_error_distance (o_err.error_distance),
    .i_out_degenerate     (o_err.degenerate)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import cre_pkg::*;

    localparam logic [2:0] REG_IDX_SPARE_A = 3'd6;
    localparam logic [2:0] REG_IDX_SPARE_B = 3'd7;
    localparam int NUM_MAT_REGS = 6;
    localparam int SETTLE_CYCLES = 90;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [31:0] M_ONE = 32'sh0100_0000;
    localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
        logic signed [31:0] ww;
        logic signed [31:0] iu;
        logic signed [31:0] iv;
    } point_t;

    typedef struct {
        logic [31:0] err_dist;
        logic        degen;
    } reproj_t;

    logic i_clk;
    logic i_rst_n;

    cre_pt_if  pt();
    cre_cfg_if cfg();
    cre_err_if err();

    camera_reprojection_error_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt),
        .i_cfg   (cfg),
        .o_err   (err)
    );

    point_t      pending_points[$];
    reproj_t     expected_errors[$];
    point_t      driven_point;
    logic [63:0] cam_shadow[NUM_MAT_REGS];
    int          mismatches;
    int          send_gap;
    int          recv_stall;
    int          cycle_count;
    bit          quiet;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [31:0] isqrt(input logic [63:0] s);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem = s;
        root = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root[31:0];
    endfunction

    function automatic reproj_t project_error(input point_t p);
        logic signed [31:0] wv[4];
        logic signed [31:0] coef;
        logic signed [63:0] prod;
        logic signed [65:0] proj[3];
        logic [65:0]        pmag[3];
        logic [81:0]        quo;
        logic signed [40:0] q;
        logic signed [40:0] meas;
        logic signed [40:0] d;
        logic [40:0]        dm;
        logic [65:0]        ssum;
        logic               sat;
        reproj_t            res;
        wv[0] = p.wx; wv[1] = p.wy; wv[2] = p.wz; wv[3] = p.ww;
        for (int r = 0; r < 3; r++) begin
            proj[r] = 0;
            for (int c = 0; c < 4; c++) begin
                coef = cam_shadow[r * 2 + c / 2][(c % 2) * 32 +: 32];
                prod = coef * wv[c];
                proj[r] = proj[r] + (prod >>> 2);
            end
            pmag[r] = proj[r] < 0 ? -proj[r] : proj[r];
        end
        if (proj[2] == 0) begin
            res.err_dist = 32'hFFFF_FFFF;
            res.degen = 1'b1;
            return res;
        end
        sat = 1'b0;
        ssum = 0;
        for (int r = 0; r < 2; r++) begin
            quo = {pmag[r], 16'b0} / pmag[2];
            if (quo >= 82'd1 << 34) quo = 82'd1 << 34;
            q = ((proj[r] < 0) != (proj[2] < 0)) ? -$signed({6'b0, quo[34:0]})
                                                 : $signed({6'b0, quo[34:0]});
            meas = (r == 0) ? p.iu : p.iv;
            d = meas - q;
            dm = d < 0 ? -d : d;
            if (dm >= 41'd1 << 32) sat = 1'b1;
            else ssum = ssum + dm * dm;
        end
        if (ssum[65:64] != 0) sat = 1'b1;
        res.err_dist = sat ? 32'hFFFF_FFFF : isqrt(ssum[63:0]);
        res.degen = 1'b0;
        return res;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom % 8)
            0: return $urandom;
            1: case ($urandom % 4)
                0: return S_MAX;
                1: return S_MIN;
                2: return 0;
                default: return -1;
            endcase
            default: return int'($urandom_range(0, 2097152)) - 1048576;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_coef();
        case ($urandom % 8)
            0: return $urandom;
            1: return ($urandom % 2) ? S_MAX : S_MIN;
            default: return int'($urandom_range(0, 67108864)) - 33554432;
        endcase
    endfunction

    function automatic point_t make_point(input logic signed [31:0] x, y, z, w, u, v);
        point_t p;
        p.wx = x; p.wy = y; p.wz = z; p.ww = w; p.iu = u; p.iv = v;
        return p;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do @(posedge i_clk); while (!(cfg.valid && cfg.ready));
        cfg.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_points.size() != 0 || pt.valid || expected_errors.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_random(input int count);
        point_t p;
        repeat (count) begin
            p = make_point(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                           rand_coord(), rand_coord());
            if ($urandom % 16 == 0) p.ww = 0;
            if ($urandom % 24 == 0) begin
                p.wx = 0; p.wy = 0; p.wz = 0; p.ww = 0;
            end
            pending_points.push_back(p);
        end
    endtask

    task automatic load_random_matrix();
        for (int i = 0; i < NUM_MAT_REGS; i++) write_reg(i[2:0], {rand_coef(), rand_coef()});
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && cfg.valid && cfg.ready && cfg.index < NUM_MAT_REGS)
            cam_shadow[cfg.index] <= cfg.data;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pt.valid <= 1'b0;
        end else begin
            if (pt.valid && pt.ready) expected_errors.push_back(project_error(driven_point));
            if (!pt.valid || pt.ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    pt.valid <= 1'b0;
                end else if (pending_points.size() != 0) begin
                    driven_point = pending_points.pop_front();
                    pt.world_x <= driven_point.wx;
                    pt.world_y <= driven_point.wy;
                    pt.world_z <= driven_point.wz;
                    pt.world_w <= driven_point.ww;
                    pt.image_u <= driven_point.iu;
                    pt.image_v <= driven_point.iv;
                    pt.valid <= 1'b1;
                    if (!quiet && $urandom % 10 == 0) send_gap <= $urandom_range(1, 10);
                end else begin
                    pt.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        reproj_t want;
        if (i_rst_n && err.valid && err.ready) begin
            if (expected_errors.size() == 0) begin
                report("unexpected transaction", err.error_distance, 0);
            end else begin
                want = expected_errors.pop_front();
                if (err.error_distance !== want.err_dist)
                    report("error_distance", err.error_distance, want.err_dist);
                if (err.degenerate !== want.degen)
                    report("degenerate", err.degenerate, want.degen);
            end
        end
        if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            err.ready <= 1'b0;
        end else begin
            err.ready <= 1'b1;
            if (!quiet && $urandom % 10 == 0) recv_stall <= $urandom_range(1, 10);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        send_gap = 0;
        recv_stall = 0;
        cycle_count = 0;
        quiet = 1'b0;
        for (int i = 0; i < NUM_MAT_REGS; i++) cam_shadow[i] = 0;
        pt.valid = 1'b0;
        pt.world_x = 0; pt.world_y = 0; pt.world_z = 0; pt.world_w = 0;
        pt.image_u = 0; pt.image_v = 0;
        cfg.valid = 1'b0;
        cfg.index = 0;
        cfg.data = 0;
        err.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_points.push_back(make_point(Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, 0));
        pending_points.push_back(make_point(S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN));
        wait_idle();

        write_reg(REG_ROW0_FIRST, {32'sh0, M_ONE});
        write_reg(REG_ROW0_SECOND, 64'h0);
        write_reg(REG_ROW1_FIRST, {M_ONE, 32'sh0});
        write_reg(REG_ROW1_SECOND, 64'h0);
        write_reg(REG_ROW2_FIRST, 64'h0);
        write_reg(REG_ROW2_SECOND, {M_ONE, 32'sh0});
        write_reg(REG_IDX_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_IDX_SPARE_B, 64'h1234_5678_9ABC_DEF0);
        pending_points.push_back(make_point(3 * Q_ONE, 4 * Q_ONE, 0, Q_ONE, 0, 0));
        pending_points.push_back(make_point(Q_ONE, 2 * Q_ONE, 0, Q_ONE, Q_ONE, 2 * Q_ONE));
        pending_points.push_back(make_point(Q_ONE, Q_ONE, 0, -Q_ONE, Q_ONE, Q_ONE));
        pending_points.push_back(make_point(Q_ONE, Q_ONE, 0, 0, 0, 0));
        pending_points.push_back(make_point(0, 0, S_MAX, 0, 0, 0));
        pending_points.push_back(make_point(S_MAX, 0, 0, 1, 0, 0));
        pending_points.push_back(make_point(S_MIN, S_MIN, 0, 1, 0, 0));
        pending_points.push_back(make_point(0, 0, 0, Q_ONE, S_MAX, S_MAX));
        pending_points.push_back(make_point(0, 0, 0, Q_ONE, S_MIN, S_MIN));
        pending_points.push_back(make_point(0, 0, 0, Q_ONE, S_MIN, 0));
        pending_points.push_back(make_point(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
        pending_points.push_back(make_point(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
        pending_points.push_back(make_point(S_MIN, S_MAX, 0, S_MIN, 0, 0));
        pending_points.push_back(make_point(-1, -1, -1, -1, -1, -1));
        pending_points.push_back(make_point(5, 7, 0, 3, 1, 2));
        pending_points.push_back(make_point(-5, 7, 0, 3, -1, 2));
        pending_points.push_back(make_point(32'sh0001_8000, 0, 0, 32'sh0000_8000, 0, 0));
        load_random(200);
        wait_idle();

        write_reg(REG_ROW0_FIRST, {S_MIN, S_MAX});
        write_reg(REG_ROW0_SECOND, {S_MAX, S_MIN});
        write_reg(REG_ROW1_FIRST, {S_MAX, S_MAX});
        write_reg(REG_ROW1_SECOND, {S_MIN, S_MIN});
        write_reg(REG_ROW2_FIRST, {S_MIN, S_MAX});
        write_reg(REG_ROW2_SECOND, {S_MAX, S_MAX});
        pending_points.push_back(make_point(S_MIN, S_MIN, S_MIN, S_MIN, 0, 0));
        pending_points.push_back(make_point(S_MAX, S_MAX, S_MAX, S_MAX, 0, 0));
        load_random(100);
        wait_idle();

        load_random_matrix();
        load_random(250);
        wait_idle();

        load_random_matrix();
        load_random(250);
        wait_idle();

        load_random_matrix();
        quiet = 1'b1;
        load_random(250);
        wait_idle();

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
